### rtl/srsig_pkg.sv
`timescale 1ns / 1ps

package srsig_pkg;

    // Datapath micro-operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAP,
        OP_ST_SQ,
        OP_ST_NUM,
        OP_ST_BOUND,
        OP_ST_SMUL,
        OP_ST_RECIP,
        OP_ST_PKS,
        OP_ST_PKL,
        OP_ST_TM1,
        OP_ST_TM2,
        OP_ST_FIN,
        OP_RP_TRIG,
        OP_RP_IDX,
        OP_RP_TA,
        OP_RP_TB,
        OP_RP_INT,
        OP_RP_T,
        OP_RP_SPD,
        OP_RP_SPD2,
        OP_RP_FIN,
        OP_STEADY,
        OP_DONE,
        OP_LOAD
    } t_op;

    typedef enum logic [1:0] {
        PH_ACCEL,
        PH_STEADY,
        PH_DECEL
    } t_phase;

    typedef enum logic [1:0] {
        REG_TICK_RATE,
        REG_MIN_SPEED,
        REG_TICK_SCALE,
        REG_START_INT
    } t_reg;

    typedef struct packed {
        t_op  op;
        logic div_start;
        logic sqrt_start;
    } t_cmd;

    typedef struct packed {
        logic kind;
        logic step_lt_tgt;
        logic is_steady;
        logic short_move;
        logic div_done;
        logic sqrt_done;
        logic steady_entry;
    } t_sts;

    typedef struct packed {
        logic [23:0] tick_rate;
        logic [15:0] min_speed;
        logic [15:0] tick_scale;
        logic [31:0] start_interval;
    } t_cfg;

    localparam logic [23:0] TICK_RATE_RST   = 24'd14400000;
    localparam logic [15:0] MIN_SPEED_RST   = 16'd30;
    localparam logic [15:0] TICK_SCALE_RST  = 16'd149;
    localparam logic [31:0] START_INT_RST   = 32'd480000;

    localparam logic [31:0] HALF_TURN       = 32'h7fffffff;
    localparam logic [31:0] QUARTER_TURN    = 32'h3fffffff;
    localparam logic [31:0] ROUND_T         = 32'h00004000;
    localparam logic [31:0] ROUND_SPEED     = 32'h00000080;
    localparam logic [31:0] K_355           = 32'd355;
    localparam logic [31:0] K_226           = 32'd226;
    localparam logic [31:0] K_452           = 32'd452;
    localparam logic [31:0] K_113           = 32'd113;

    // Reciprocal of 355 scaled by 2^40, rounded up; exact for any 32-bit dividend.
    localparam logic [31:0] RECIP_355       = 32'd3097215853;

    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam longint unsigned TAYLOR_DEN [12] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
        64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
    };

endpackage

### rtl/srsig_div.sv
`timescale 1ns / 1ps

module srsig_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quot
);

    // Restoring divider, one quotient bit per cycle. A zero divisor
    // naturally yields all ones.
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] sh;
    logic [32:0] diff;

    assign sh   = {r_rem, r_quo[31]};
    assign diff = sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            if (!diff[32]) begin
                r_rem <= diff[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= sh[31:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

### rtl/srsig_sqrt.sv
`timescale 1ns / 1ps

module srsig_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_x,
    output logic        o_done,
    output logic [31:0] o_root
);

    // Bitwise square root of x * 2^31, two radicand bits per cycle.
    // An operand with the top bit set gives zero.
    logic [63:0] r_v;
    logic [63:0] r_r;
    logic [63:0] r_bit;
    logic        r_busy;
    logic        r_done;
    logic [63:0] trial;

    assign trial = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit == 64'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_x[31] ? 64'd0 : (64'(i_x[30:0]) << 31);
            r_r   <= '0;
            r_bit <= 64'd1 << 62;
        end else if (r_busy) begin
            if (r_v >= trial) begin
                r_v <= r_v - trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[47:16];

endmodule

### rtl/srsig_dp.sv
`timescale 1ns / 1ps

module srsig_dp #(
    parameter int COS_TABLE_SIZE = 512
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  srsig_pkg::t_cmd   i_cmd,
    input  srsig_pkg::t_cfg   i_cfg,
    input  logic              i_kind,
    input  logic [15:0]       i_target_steps,
    input  logic [15:0]       i_accel_limit,
    input  logic [15:0]       i_speed_limit,
    output srsig_pkg::t_sts   o_sts,
    output logic [31:0]       o_interval_ticks,
    output logic [31:0]       o_speed_q8,
    output logic [1:0]        o_phase,
    output logic              o_finished
);

    import srsig_pkg::*;

    localparam int HALF = COS_TABLE_SIZE / 2;
    localparam int KW   = $clog2(COS_TABLE_SIZE + 1);
    localparam int IW   = $clog2(COS_TABLE_SIZE);
    localparam int MW   = $clog2(HALF + 1);
    localparam int FW   = KW + 2;
    localparam int PW   = 31 + KW;
    localparam logic [FW-1:0] N_F = FW'(COS_TABLE_SIZE);
    localparam logic [PW-1:0] N_P = PW'(COS_TABLE_SIZE);

    // Cosine of pi*m/N in q31 magnitude, from a Taylor series in q30.
    function automatic logic [30:0] cos_entry(input int m);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          v;
        x    = (PI_Q30 * 64'(m)) / COS_TABLE_SIZE;
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        sum  = 64'sd1 << 30;
        for (int k = 0; k < 12; k++) begin
            term = ((term * x2) >> 30) / TAYLOR_DEN[k];
            if (!k[0]) sum = sum - longint'(term);
            else       sum = sum + longint'(term);
        end
        v = 2 * sum;
        if (v < 0) v = 0;
        if (v > 64'sh7fffffff) v = 64'sh7fffffff;
        return v[30:0];
    endfunction

    logic [30:0] cos_rom [HALF+1];

    for (genvar g = 0; g <= HALF; g++) begin : g_rom
        assign cos_rom[g] = cos_entry(g);
    end

    // Move state
    t_phase      r_phase;
    logic [31:0] r_peak;
    logic [31:0] r_tmult;
    logic [31:0] r_elapsed;
    logic [31:0] r_speed;
    logic [31:0] r_speed_before;
    logic [31:0] r_step;
    logic [15:0] r_target;
    logic [31:0] r_steady_left;
    logic        r_wrapped;
    logic [31:0] r_last;
    logic        r_entry;

    // Working registers
    logic        r_kind;
    logic [15:0] r_tgt;
    logic [15:0] r_acc;
    logic [15:0] r_spd;
    logic [31:0] r_num;
    logic [31:0] r_den;
    logic [31:0] r_trig;
    logic [IW-1:0] r_idx;
    logic [30:0] r_frac;
    logic [31:0] r_ca;
    logic [31:0] r_cb;
    logic [32:0] r_iq;
    logic        r_ineg;
    logic [31:0] r_t;
    logic [31:0] r_t1;
    logic [31:0] r_res_int;
    logic        r_res_done;
    logic [31:0] r_o_int;
    logic [31:0] r_o_speed;
    logic [1:0]  r_o_phase;
    logic        r_o_fin;

    logic        div_done;
    logic [31:0] div_quot;
    logic        sqrt_done;
    logic [31:0] sqrt_root;

    srsig_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_num),
        .i_divisor  (r_den),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    srsig_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_x     (r_num),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    // Table lookup with the quarter-wave fold.
    logic [FW-1:0] k_f;
    logic [FW-1:0] r_f;
    logic [FW-1:0] m_f;
    logic          neg;
    logic [31:0]   tab_val;
    logic [31:0]   mag32;

    always_comb begin
        k_f = (i_cmd.op == OP_RP_TB) ? FW'(r_idx) + FW'(1) : FW'(r_idx);
        r_f = (k_f == N_F) ? '0 : k_f;
        if ((r_f << 1) > N_F) r_f = N_F - r_f;
        m_f = r_f << 1;
        neg = 1'b0;
        if ((m_f << 1) > N_F) begin
            m_f = N_F - m_f;
            neg = 1'b1;
        end
        mag32   = {1'b0, cos_rom[m_f[MW-1:0]]};
        tab_val = neg ? (32'd0 - mag32) : mag32;
    end

    // Step arithmetic
    logic [PW-1:0] p_idx;
    logic [32:0]   d33;
    logic [32:0]   dmag;
    logic [63:0]   iprod;
    logic [33:0]   a34;
    logic [33:0]   cosv;
    logic [31:0]   t0;
    logic [31:0]   s_new;
    logic [31:0]   sl_new;
    logic          peak;
    logic          sl_pos;
    logic [31:0]   sl_dec;
    logic [63:0]   recip_prod;

    always_comb begin
        p_idx  = PW'(r_trig[30:0]) * N_P;
        d33    = {r_cb[31], r_cb} - {r_ca[31], r_ca};
        dmag   = d33[32] ? (33'd0 - d33) : d33;
        iprod  = 64'(dmag) * 64'(r_frac);
        a34    = {{2{r_ca[31]}}, r_ca};
        cosv   = r_ineg ? (a34 - {1'b0, r_iq}) : (a34 + {1'b0, r_iq});
        t0     = HALF_TURN - cosv[31:0] + ROUND_T;
        s_new  = ((r_t1 + ROUND_SPEED) >> 8) + {8'd0, i_cfg.min_speed, 8'd0};
        sl_new = {16'd0, r_target} - ((r_step + 32'd1) << 1);
        peak   = (r_phase == PH_ACCEL) &&
                 ((s_new < r_speed_before) || (r_trig >= QUARTER_TURN));
        sl_pos = (sl_new != 32'd0) && !sl_new[31];
        sl_dec = r_steady_left - 32'd1;
        // Division by 355 as a multiply by its scaled reciprocal.
        recip_prod = 64'(r_num) * 64'(RECIP_355);
    end

    // Move state, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_ACCEL;
            r_peak         <= '0;
            r_tmult        <= '0;
            r_elapsed      <= '0;
            r_speed        <= '0;
            r_speed_before <= '0;
            r_step         <= '0;
            r_target       <= '0;
            r_steady_left  <= '0;
            r_wrapped      <= 1'b0;
            r_last         <= '0;
            r_entry        <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_ST_BOUND: r_target <= r_tgt;
                OP_ST_PKS:   r_peak   <= sqrt_root - {16'd0, i_cfg.min_speed};
                OP_ST_PKL:   r_peak   <= {16'd0, r_spd} - {16'd0, i_cfg.min_speed};
                OP_ST_FIN: begin
                    r_tmult        <= div_quot;
                    r_elapsed      <= i_cfg.start_interval;
                    r_speed_before <= '0;
                    r_step         <= 32'd1;
                    r_speed        <= {8'd0, i_cfg.min_speed, 8'd0};
                    r_wrapped      <= 1'b0;
                end
                OP_RP_IDX: begin
                    if (r_trig > HALF_TURN) r_wrapped <= 1'b1;
                end
                OP_RP_SPD2: begin
                    r_entry <= 1'b0;
                    r_speed <= s_new;
                    if (peak) begin
                        r_steady_left <= sl_new;
                        if (sl_pos) begin
                            r_phase <= PH_STEADY;
                            r_speed <= r_speed_before;
                            r_entry <= 1'b1;
                        end else begin
                            r_phase <= PH_DECEL;
                        end
                    end else if (r_wrapped) begin
                        r_phase <= PH_ACCEL;
                    end
                end
                OP_RP_FIN: begin
                    r_elapsed      <= r_elapsed + div_quot;
                    r_last         <= div_quot;
                    r_step         <= r_step + 32'd1;
                    r_speed_before <= r_speed;
                end
                OP_STEADY: begin
                    r_steady_left <= sl_dec;
                    if (sl_dec != 32'd0 && !sl_dec[31]) r_step  <= r_step + 32'd1;
                    else                                 r_phase <= PH_DECEL;
                end
                OP_DONE: begin
                    r_last    <= '0;
                    r_wrapped <= 1'b0;
                    r_phase   <= PH_ACCEL;
                end
                default: ;
            endcase
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAP: begin
                r_kind <= i_kind;
                r_tgt  <= i_target_steps;
                r_acc  <= i_accel_limit;
                r_spd  <= i_speed_limit;
            end
            OP_ST_SQ:  r_num <= {16'd0, r_spd} * {16'd0, r_spd};
            OP_ST_NUM: begin
                r_num <= r_num * K_355;
                r_den <= {16'd0, r_acc} * K_226;
            end
            OP_ST_BOUND: r_num <= {16'd0, r_acc} * K_452;
            OP_ST_SMUL:  r_num <= r_num * {16'd0, r_tgt};
            OP_ST_RECIP: r_num <= {8'd0, recip_prod[63:40]};
            OP_ST_TM1: begin
                r_den <= r_peak * K_355;
                r_num <= {16'd0, r_acc} * {16'd0, i_cfg.tick_scale};
            end
            OP_ST_TM2: r_num <= r_num * K_113 + (r_den >> 1);
            OP_ST_FIN: begin
                r_res_int  <= i_cfg.start_interval;
                r_res_done <= 1'b0;
            end
            OP_RP_TRIG: r_trig <= r_elapsed * r_tmult;
            OP_RP_IDX: begin
                r_idx  <= p_idx[31+IW-1:31];
                r_frac <= p_idx[30:0];
            end
            OP_RP_TA: r_ca <= tab_val;
            OP_RP_TB: r_cb <= tab_val;
            OP_RP_INT: begin
                r_iq   <= iprod[63:31];
                r_ineg <= d33[32];
            end
            OP_RP_T:   r_t  <= t0 >> 15;
            OP_RP_SPD: r_t1 <= {1'b0, r_peak[31:1]} * r_t;
            OP_RP_SPD2: begin
                r_num      <= {i_cfg.tick_rate, 8'd0} + (s_new >> 1);
                r_den      <= s_new;
                r_res_int  <= r_last;
                r_res_done <= 1'b0;
            end
            OP_RP_FIN: r_res_int <= div_quot;
            OP_STEADY: begin
                r_res_int  <= r_last;
                r_res_done <= 1'b0;
            end
            OP_DONE: begin
                r_res_int  <= '0;
                r_res_done <= 1'b1;
            end
            OP_LOAD: begin
                r_o_int   <= r_res_int;
                r_o_speed <= r_speed;
                r_o_phase <= r_phase;
                r_o_fin   <= r_res_done;
            end
            default: ;
        endcase
    end

    assign o_sts.kind         = r_kind;
    assign o_sts.step_lt_tgt  = r_step < {16'd0, r_target};
    assign o_sts.is_steady    = (r_phase == PH_STEADY);
    assign o_sts.short_move   = r_tgt < div_quot[15:0];
    assign o_sts.div_done     = div_done;
    assign o_sts.sqrt_done    = sqrt_done;
    assign o_sts.steady_entry = r_entry;

    assign o_interval_ticks = r_o_int;
    assign o_speed_q8       = r_o_speed;
    assign o_phase          = r_o_phase;
    assign o_finished       = r_o_fin;

endmodule

### rtl/srsig_ctrl.sv
`timescale 1ns / 1ps

module srsig_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  srsig_pkg::t_sts i_sts,
    output srsig_pkg::t_cmd o_cmd
);

    import srsig_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP,
        S_ST_SQ, S_ST_NUM, S_ST_DIV1, S_ST_BOUND, S_ST_SMUL, S_ST_RECIP,
        S_ST_SQRT, S_ST_PKS, S_ST_PKL, S_ST_TM1, S_ST_TM2, S_ST_DIV3, S_ST_FIN,
        S_RP_TRIG, S_RP_IDX, S_RP_TA, S_RP_TB, S_RP_INT, S_RP_T, S_RP_SPD,
        S_RP_SPD2, S_RP_CHK, S_RP_DIV, S_RP_FIN,
        S_STEADY, S_DONE, S_LOAD
    } t_state;

    t_state r_state, n_state;
    logic   r_launched, n_launched;
    logic   r_out_valid, n_out_valid;
    t_cmd   cmd;

    always_comb begin
        n_state     = r_state;
        n_launched  = r_launched;
        n_out_valid = (r_out_valid && !i_out_stall) ? 1'b0 : r_out_valid;
        cmd         = '{op: OP_NONE, div_start: 1'b0, sqrt_start: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.op  = OP_CAP;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (!i_sts.kind)            n_state = S_ST_SQ;
                else if (!i_sts.step_lt_tgt) n_state = S_DONE;
                else if (i_sts.is_steady)   n_state = S_STEADY;
                else                        n_state = S_RP_TRIG;
            end
            S_ST_SQ:  begin cmd.op = OP_ST_SQ;  n_state = S_ST_NUM; end
            S_ST_NUM: begin cmd.op = OP_ST_NUM; n_state = S_ST_DIV1; end
            S_ST_DIV1, S_ST_DIV3, S_RP_DIV: begin
                if (!r_launched) begin
                    cmd.div_start = 1'b1;
                    n_launched    = 1'b1;
                end else if (i_sts.div_done) begin
                    n_launched = 1'b0;
                    unique case (r_state)
                        S_ST_DIV1: n_state = S_ST_BOUND;
                        S_ST_DIV3: n_state = S_ST_FIN;
                        default:   n_state = S_RP_FIN;
                    endcase
                end
            end
            S_ST_BOUND: begin
                cmd.op  = OP_ST_BOUND;
                n_state = i_sts.short_move ? S_ST_SMUL : S_ST_PKL;
            end
            S_ST_SMUL:  begin cmd.op = OP_ST_SMUL;  n_state = S_ST_RECIP; end
            S_ST_RECIP: begin cmd.op = OP_ST_RECIP; n_state = S_ST_SQRT; end
            S_ST_SQRT: begin
                if (!r_launched) begin
                    cmd.sqrt_start = 1'b1;
                    n_launched     = 1'b1;
                end else if (i_sts.sqrt_done) begin
                    n_launched = 1'b0;
                    n_state    = S_ST_PKS;
                end
            end
            S_ST_PKS:  begin cmd.op = OP_ST_PKS;  n_state = S_ST_TM1; end
            S_ST_PKL:  begin cmd.op = OP_ST_PKL;  n_state = S_ST_TM1; end
            S_ST_TM1:  begin cmd.op = OP_ST_TM1;  n_state = S_ST_TM2; end
            S_ST_TM2:  begin cmd.op = OP_ST_TM2;  n_state = S_ST_DIV3; end
            S_ST_FIN:  begin cmd.op = OP_ST_FIN;  n_state = S_LOAD; end
            S_RP_TRIG: begin cmd.op = OP_RP_TRIG; n_state = S_RP_IDX; end
            S_RP_IDX:  begin cmd.op = OP_RP_IDX;  n_state = S_RP_TA; end
            S_RP_TA:   begin cmd.op = OP_RP_TA;   n_state = S_RP_TB; end
            S_RP_TB:   begin cmd.op = OP_RP_TB;   n_state = S_RP_INT; end
            S_RP_INT:  begin cmd.op = OP_RP_INT;  n_state = S_RP_T; end
            S_RP_T:    begin cmd.op = OP_RP_T;    n_state = S_RP_SPD; end
            S_RP_SPD:  begin cmd.op = OP_RP_SPD;  n_state = S_RP_SPD2; end
            S_RP_SPD2: begin cmd.op = OP_RP_SPD2; n_state = S_RP_CHK; end
            S_RP_CHK: begin
                n_state = i_sts.steady_entry ? S_LOAD : S_RP_DIV;
            end
            S_RP_FIN:  begin cmd.op = OP_RP_FIN;  n_state = S_LOAD; end
            S_STEADY:  begin cmd.op = OP_STEADY;  n_state = S_LOAD; end
            S_DONE:    begin cmd.op = OP_DONE;    n_state = S_LOAD; end
            S_LOAD: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd.op      = OP_LOAD;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_launched  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_launched  <= n_launched;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### rtl/sine_ramp_step_interval_gen.sv
`timescale 1ns / 1ps

// Stepper pulse-interval generator with a raised-cosine speed ramp.
// The input channel (i_in_valid / o_in_stall) takes one transaction per
// item: kind 0 plans a move from target steps, acceleration and speed
// limits; kind 1 asks for the next pulse interval. Every transaction
// produces exactly one result transaction on the output channel
// (o_out_valid / i_out_stall) with the interval, the q8 speed, the phase
// and a finished flag.
// Items are processed one at a time by a state machine driving a 32-bit
// radix-2 divider and a bitwise square-root unit; the input is free again
// as the result is loaded. The result sits in an output register, so a new
// transaction is taken while it waits; if the receiver still stalls when
// the next result is ready, the block holds that result and stalls the
// input. Synchronous reset clears the move state and the output valid flag
// and loads the reset values into the configuration registers.
// The APB port writes the four configuration registers at 0x0, 0x4, 0x8
// and 0xC; they may only be changed while no transaction is in flight.
module sine_ramp_step_interval_gen #(
    parameter int COS_TABLE_SIZE = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [15:0] i_target_steps,
    input  logic [15:0] i_accel_limit,
    input  logic [15:0] i_speed_limit,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_interval_ticks,
    output logic [31:0] o_speed_q8,
    output logic [1:0]  o_phase,
    output logic        o_finished,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import srsig_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;
    t_reg reg_sel;

    assign reg_sel = t_reg'(paddr[3:2]);
    assign pready  = 1'b1;

    // Configuration registers: written on the APB access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tick_rate      <= TICK_RATE_RST;
            r_cfg.min_speed      <= MIN_SPEED_RST;
            r_cfg.tick_scale     <= TICK_SCALE_RST;
            r_cfg.start_interval <= START_INT_RST;
        end else if (psel && penable && pwrite) begin
            unique case (reg_sel)
                REG_TICK_RATE:  r_cfg.tick_rate      <= pwdata[23:0];
                REG_MIN_SPEED:  r_cfg.min_speed      <= pwdata[15:0];
                REG_TICK_SCALE: r_cfg.tick_scale     <= pwdata[15:0];
                REG_START_INT:  r_cfg.start_interval <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_TICK_RATE:  prdata = {8'd0, r_cfg.tick_rate};
            REG_MIN_SPEED:  prdata = {16'd0, r_cfg.min_speed};
            REG_TICK_SCALE: prdata = {16'd0, r_cfg.tick_scale};
            REG_START_INT:  prdata = r_cfg.start_interval;
            default:        prdata = '0;
        endcase
    end

    srsig_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    srsig_dp #(
        .COS_TABLE_SIZE (COS_TABLE_SIZE)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_cfg            (r_cfg),
        .i_kind           (i_kind),
        .i_target_steps   (i_target_steps),
        .i_accel_limit    (i_accel_limit),
        .i_speed_limit    (i_speed_limit),
        .o_sts            (sts),
        .o_interval_ticks (o_interval_ticks),
        .o_speed_q8       (o_speed_q8),
        .o_phase          (o_phase),
        .o_finished       (o_finished)
    );

    // An accepted transaction keeps the input stalled while it is worked on.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepting a transaction");

    // A finished result carries a zero interval and the accelerate phase.
    a_finished_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_finished) |-> (o_interval_ticks == 32'd0 &&
                                         o_phase == PH_ACCEL))
        else $error("finished result with nonzero interval or wrong phase");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import srsig_pkg::*;

    // One input transaction, and one result transaction, of the interval generator.
    typedef struct {
        logic        kind;
        logic [15:0] tgt;
        logic [15:0] acc;
        logic [15:0] spd;
    } t_motion_req;

    typedef struct {
        logic [31:0] interval;
        logic [31:0] speed;
        logic [1:0]  phase;
        logic        done;
    } t_pulse_res;

    localparam int COS_N      = 512;
    localparam int STALL_LIMIT = 5000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_kind = 1'b0;
    logic [15:0] i_target_steps = '0;
    logic [15:0] i_accel_limit = '0;
    logic [15:0] i_speed_limit = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_interval_ticks;
    logic [31:0] o_speed_q8;
    logic [1:0]  o_phase;
    logic        o_finished;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    sine_ramp_step_interval_gen u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state: configuration copy and the move state.
    logic [31:0] cfg_rate, cfg_min, cfg_scale, cfg_first;
    t_phase      mv_phase;
    logic [31:0] mv_peak, mv_mult, mv_ticks, mv_speed, mv_prev_speed, mv_step;
    logic [31:0] mv_target, mv_steady_left, mv_last_int;
    logic        mv_wrapped;
    longint      cos_lut [0:COS_N];

    t_motion_req pending_reqs[$];
    t_pulse_res  expected_pulses[$];
    int          err_count = 0;
    bit          in_fire = 0;
    int          drv_gap = 0;
    int          rcv_gap = 0;
    bit          quiet_mode = 0;
    int          hold_ask = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          idle_cycles = 0;

    function automatic logic [31:0] div_sat(logic [31:0] a, logic [31:0] b);
        return (b == 0) ? 32'hffffffff : a / b;
    endfunction

    // Taylor series for cosine in q30, twelve terms.
    function automatic longint cos_series(longint unsigned x);
        longint unsigned x2, term;
        longint sum;
        x2 = (x * x) >> 30;
        term = 64'd1 << 30;
        sum = longint'(term);
        for (int k = 1; k <= 12; k++) begin
            term = ((term * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) sum -= longint'(term);
            else sum += longint'(term);
        end
        return sum;
    endfunction

    function automatic void fill_cos_lut();
        longint unsigned r, m;
        longint v;
        bit neg;
        for (int k = 0; k <= COS_N; k++) begin
            r = k % COS_N;
            neg = 0;
            if (2 * r > COS_N) r = COS_N - r;
            m = 2 * r;
            if (2 * m > COS_N) begin
                m = COS_N - m;
                neg = 1;
            end
            v = 2 * cos_series((PI_Q30 * m) / COS_N);
            if (v < 0) v = 0;
            if (v > 64'h7fffffff) v = 64'h7fffffff;
            cos_lut[k] = neg ? -v : v;
        end
    endfunction

    // Interpolated cosine in q31; the angle's low 31 bits are one full turn.
    function automatic longint cos_interp(logic [31:0] angle);
        longint unsigned p, idx, f;
        longint a, d;
        p = longint'(angle[30:0]) * COS_N;
        idx = p >> 31;
        f = p & 64'h7fffffff;
        a = cos_lut[idx];
        d = cos_lut[idx + 1] - a;
        if (d >= 0) return a + longint'((unsigned'(d) * f) >> 31);
        return a - longint'((unsigned'(-d) * f) >> 31);
    endfunction

    function automatic logic [31:0] peak_root(logic [31:0] x);
        longint unsigned v, r, b;
        if (x > 32'h7fffffff) return 0;
        v = longint'(x) << 31;
        r = 0;
        b = 64'd1 << 62;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r[47:16];
    endfunction

    function automatic void plan_move(t_motion_req q);
        logic [31:0] sq, bound, den, acc, spd;
        acc = {16'd0, q.acc};
        spd = {16'd0, q.spd};
        sq = spd * spd;
        bound = div_sat(sq * K_355, acc * K_226) & 32'hffff;
        mv_target = {16'd0, q.tgt};
        if (mv_target < bound)
            mv_peak = peak_root((K_452 * acc * mv_target) / K_355) - cfg_min;
        else
            mv_peak = spd - cfg_min;
        den = mv_peak * K_355;
        mv_mult = div_sat(acc * cfg_scale * K_113 + den / 2, den);
        mv_ticks = cfg_first;
        mv_prev_speed = 0;
        mv_step = 1;
        mv_speed = cfg_min << 8;
        mv_wrapped = 0;
    endfunction

    // One point on the raised-cosine ramp, with the phase decision.
    function automatic void ramp_step();
        logic [31:0] trig, t, dt, cosv;
        bit at_peak;
        trig = mv_ticks * mv_mult;
        if (trig > HALF_TURN) mv_wrapped = 1;
        cosv = 32'(cos_interp(trig));
        t = HALF_TURN - cosv;
        t += ROUND_T;
        t >>= 15;
        mv_speed = (mv_peak / 2) * t;
        mv_speed += ROUND_SPEED;
        mv_speed >>= 8;
        mv_speed += cfg_min << 8;
        at_peak = (mv_phase == PH_ACCEL) &&
                  (mv_speed < mv_prev_speed || trig >= QUARTER_TURN);
        if (at_peak) begin
            mv_steady_left = mv_target - 2 * (mv_step + 1);
            if (mv_steady_left != 0 && mv_steady_left < 32'h80000000) begin
                mv_phase = PH_STEADY;
                mv_speed = mv_prev_speed;
                return;
            end
            mv_phase = PH_DECEL;
        end else if (mv_wrapped) begin
            mv_phase = PH_ACCEL;
        end
        dt = div_sat((cfg_rate << 8) + (mv_speed >> 1), mv_speed);
        mv_ticks += dt;
        mv_last_int = dt;
        mv_step++;
        mv_prev_speed = mv_speed;
    endfunction

    function automatic t_pulse_res predict_pulse(t_motion_req q);
        t_pulse_res res;
        res.done = 0;
        if (!q.kind) begin
            plan_move(q);
            res.interval = cfg_first;
        end else if (mv_step < mv_target) begin
            if (mv_phase == PH_STEADY) begin
                mv_steady_left--;
                if (mv_steady_left != 0 && mv_steady_left < 32'h80000000) mv_step++;
                else mv_phase = PH_DECEL;
            end else begin
                ramp_step();
            end
            res.interval = mv_last_int;
        end else begin
            mv_last_int = 0;
            mv_wrapped = 0;
            mv_phase = PH_ACCEL;
            res.interval = 0;
            res.done = 1;
        end
        res.speed = mv_speed;
        res.phase = mv_phase;
        return res;
    endfunction

    // Gap lengths: mostly short, a few long, none in quiet stretches.
    function automatic int pick_gap();
        int r;
        if (quiet_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Input side monitor: a transaction updates the predictor.
    always @(posedge i_clk) begin
        in_fire = i_rst_n && i_in_valid && !o_in_stall;
        if (in_fire)
            expected_pulses.push_back(predict_pulse('{i_kind, i_target_steps,
                                                      i_accel_limit, i_speed_limit}));
    end

    // Output side monitor: compare each result with the oldest expectation.
    always @(posedge i_clk) begin
        t_pulse_res e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pulses.size() == 0) begin
                $display("%0t: unexpected result interval %h", $realtime, o_interval_ticks);
                err_count++;
            end else begin
                e = expected_pulses.pop_front();
                if (o_interval_ticks !== e.interval) begin
                    $display("%0t: interval exp %h got %h", $realtime, e.interval,
                             o_interval_ticks);
                    err_count++;
                end
                if (o_speed_q8 !== e.speed) begin
                    $display("%0t: speed exp %h got %h", $realtime, e.speed, o_speed_q8);
                    err_count++;
                end
                if (o_phase !== e.phase) begin
                    $display("%0t: phase exp %0d got %0d", $realtime, e.phase, o_phase);
                    err_count++;
                end
                if (o_finished !== e.done) begin
                    $display("%0t: finished exp %0d got %0d", $realtime, e.done, o_finished);
                    err_count++;
                end
            end
        end
    end

    // Driver: the payload holds while stalled; gaps come between transactions.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                void'(pending_reqs.pop_front());
                drv_gap = pick_gap();
            end
            if (!(i_in_valid && !in_fire)) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    i_in_valid     <= 1'b1;
                    i_kind         <= pending_reqs[0].kind;
                    i_target_steps <= pending_reqs[0].tgt;
                    i_accel_limit  <= pending_reqs[0].acc;
                    i_speed_limit  <= pending_reqs[0].spd;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is asked for.
    always @(negedge i_clk) begin
        if (hold_ask != hold_seen) begin
            hold_seen++;
            hold_left = 600;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (rcv_gap > 0) begin
            rcv_gap--;
            i_out_stall <= 1'b1;
        end else begin
            rcv_gap = pick_gap();
            i_out_stall <= (rcv_gap > 0);
        end
    end

    // Watchdog: too many cycles with work outstanding and no transaction.
    always @(posedge i_clk) begin
        if ((pending_reqs.size() > 0 || expected_pulses.size() > 0) &&
            !(i_in_valid && !o_in_stall) && !(o_out_valid && !i_out_stall)) begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb: done, errors");
                $finish;
            end
        end else begin
            idle_cycles = 0;
        end
    end

    task automatic reg_write(t_reg idx, logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(idx) << 2;
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TICK_RATE:  cfg_rate  = {8'd0, val[23:0]};
            REG_MIN_SPEED:  cfg_min   = {16'd0, val[15:0]};
            REG_TICK_SCALE: cfg_scale = {16'd0, val[15:0]};
            REG_START_INT:  cfg_first = val;
        endcase
    endtask

    task automatic set_config(logic [23:0] rate, logic [15:0] mn, logic [15:0] sc,
                              logic [31:0] first);
        reg_write(REG_TICK_RATE, {8'd0, rate});
        reg_write(REG_MIN_SPEED, {16'd0, mn});
        reg_write(REG_TICK_SCALE, {16'd0, sc});
        reg_write(REG_START_INT, first);
    endtask

    task automatic queue_req(logic kind, logic [15:0] tgt, logic [15:0] acc,
                             logic [15:0] spd);
        pending_reqs.push_back('{kind, tgt, acc, spd});
    endtask

    task automatic queue_move(logic [15:0] tgt, logic [15:0] acc, logic [15:0] spd,
                              int n_steps);
        queue_req(1'b0, tgt, acc, spd);
        for (int i = 0; i < n_steps; i++)
            queue_req(1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // Random moves: mostly run to completion, some cut short, some noise.
    task automatic queue_random(int n_items);
        int made, r, tgt, steps;
        made = 0;
        while (made < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                queue_req(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
                made++;
            end else begin
                if (r < 14) tgt = $urandom_range(0, 65535);
                else tgt = $urandom_range(0, 40);
                steps = (tgt < 45) ? tgt + $urandom_range(0, 3) : $urandom_range(1, 30);
                if ($urandom_range(0, 9) < 7)
                    queue_move(16'(tgt), 16'($urandom_range(50, 20000)),
                               16'($urandom_range(40, 3000)), steps);
                else
                    queue_move(16'(tgt), 16'($urandom), 16'($urandom), steps);
                made += steps + 1;
            end
        end
    endtask

    // Let everything drain before the configuration changes.
    task automatic drain();
        while (pending_reqs.size() > 0 || expected_pulses.size() > 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    initial begin
        cfg_rate = 32'(TICK_RATE_RST);
        cfg_min = 32'(MIN_SPEED_RST);
        cfg_scale = 32'(TICK_SCALE_RST);
        cfg_first = START_INT_RST;
        mv_phase = PH_ACCEL;
        {mv_peak, mv_mult, mv_ticks, mv_speed, mv_prev_speed} = '0;
        {mv_step, mv_target, mv_steady_left, mv_last_int} = '0;
        mv_wrapped = 0;
        fill_cos_lut();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset configuration.
        queue_req(1'b1, 16'h0000, 16'h0000, 16'h0000);   // step before any move
        queue_move(16'd0, 16'd0, 16'd0, 1);               // zero divisors
        queue_move(16'd20, 16'd50000, 16'd300, 5);        // long move, steady
        queue_move(16'd10, 16'd1000, 16'd2000, 12);       // short move, root, finish
        queue_move(16'hffff, 16'hffff, 16'hffff, 2);      // field maxima
        queue_move(16'd5, 16'd100, 16'd10, 2);            // peak below min speed
        drain();

        quiet_mode = 1;
        queue_random(150);
        drain();
        quiet_mode = 0;

        set_config(24'd1, 16'd0, 16'd0, 32'd0);
        hold_ask++;
        queue_random(170);
        drain();

        set_config(24'hffffff, 16'hffff, 16'hffff, 32'hffffffff);
        queue_random(170);
        drain();

        set_config(TICK_RATE_RST, MIN_SPEED_RST, TICK_SCALE_RST, START_INT_RST);
        hold_ask++;
        queue_random(180);
        drain();

        set_config(24'($urandom_range(1, 24'hffffff)), 16'($urandom_range(0, 200)),
                   16'($urandom), $urandom);
        queue_random(170);
        drain();

        set_config(24'd100000, 16'd10, 16'd1000, 32'd50000);
        queue_random(170);
        drain();

        repeat (200) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

### files.f
rtl/srsig_pkg.sv
rtl/srsig_div.sv
rtl/srsig_sqrt.sv
rtl/srsig_dp.sv
rtl/srsig_ctrl.sv
rtl/sine_ramp_step_interval_gen.sv
tb/tb.sv
